// File: hdl/mxu_pkg.sv
package mxu_pkg;

  localparam logic [31:0] BevVector    = 32'hbfc00180;
  localparam logic [31:0] NormalVector = 32'h80000080;

  typedef enum logic [2:0] {
    EXC_NONE     = 3'd0,
    EXC_OVERFLOW = 3'd1,
    EXC_SYSCALL  = 3'd2,
    EXC_RESERVED = 3'd3,
    EXC_BREAK    = 3'd4,
    EXC_OUTSIDE  = 3'd5
  } exc_t;

  typedef enum logic [3:0] {
    MEM_NONE = 4'd0,
    MEM_LB   = 4'd1,
    MEM_LBU  = 4'd2,
    MEM_LH   = 4'd3,
    MEM_LHU  = 4'd4,
    MEM_LW   = 4'd5,
    MEM_SB   = 4'd6,
    MEM_SH   = 4'd7,
    MEM_SW   = 4'd8
  } mem_t;

  // long operations run on the shared multiply/divide unit
  typedef enum logic [1:0] {
    MD_MULT  = 2'd0,
    MD_MULTU = 2'd1,
    MD_DIV   = 2'd2,
    MD_DIVU  = 2'd3
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_status_t;

  // opcodes
  localparam logic [5:0] OP_SPECIAL    = 6'h00;
  localparam logic [5:0] OP_REGIMM     = 6'h01;
  localparam logic [5:0] OP_J          = 6'h02;
  localparam logic [5:0] OP_JAL        = 6'h03;
  localparam logic [5:0] OP_BEQ        = 6'h04;
  localparam logic [5:0] OP_BNE        = 6'h05;
  localparam logic [5:0] OP_BLEZ       = 6'h06;
  localparam logic [5:0] OP_BGTZ       = 6'h07;
  localparam logic [5:0] OP_ADDI       = 6'h08;
  localparam logic [5:0] OP_ADDI_NOTRAP = 6'h09;
  localparam logic [5:0] OP_SLTI       = 6'h0a;
  localparam logic [5:0] OP_SLTI_UNS   = 6'h0b;
  localparam logic [5:0] OP_ANDI       = 6'h0c;
  localparam logic [5:0] OP_ORI        = 6'h0d;
  localparam logic [5:0] OP_XORI       = 6'h0e;
  localparam logic [5:0] OP_LUI        = 6'h0f;
  localparam logic [5:0] OP_COP0       = 6'h10;
  localparam logic [5:0] OP_COP1       = 6'h11;
  localparam logic [5:0] OP_COP2       = 6'h12;
  localparam logic [5:0] OP_COP3       = 6'h13;
  localparam logic [5:0] OP_LB         = 6'h20;
  localparam logic [5:0] OP_LH         = 6'h21;
  localparam logic [5:0] OP_LWL        = 6'h22;
  localparam logic [5:0] OP_LW         = 6'h23;
  localparam logic [5:0] OP_LBU        = 6'h24;
  localparam logic [5:0] OP_LHU        = 6'h25;
  localparam logic [5:0] OP_LWR        = 6'h26;
  localparam logic [5:0] OP_SB         = 6'h28;
  localparam logic [5:0] OP_SH         = 6'h29;
  localparam logic [5:0] OP_SWL        = 6'h2a;
  localparam logic [5:0] OP_SW         = 6'h2b;
  localparam logic [5:0] OP_SWR        = 6'h2e;
  localparam logic [5:0] OP_LWC0       = 6'h30;
  localparam logic [5:0] OP_LWC1       = 6'h31;
  localparam logic [5:0] OP_LWC2       = 6'h32;
  localparam logic [5:0] OP_LWC3       = 6'h33;
  localparam logic [5:0] OP_SWC0       = 6'h38;
  localparam logic [5:0] OP_SWC1       = 6'h39;
  localparam logic [5:0] OP_SWC2       = 6'h3a;
  localparam logic [5:0] OP_SWC3       = 6'h3b;

  // function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [4:0] LinkReg = 5'd31;

endpackage

// File: hdl/mxu_muldiv.sv
module mxu_muldiv
  import mxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  md_cmd_t     cmd,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  output md_status_t  status,
  output logic [31:0] hi_res,
  output logic [31:0] lo_res
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_DFIX
  } md_state_t;

  md_state_t   state;
  logic        is_signed;
  logic        a_neg, b_neg;
  logic [31:0] ua, ub;
  logic [31:0] a_abs, b_abs;
  logic [63:0] acc;
  logic [31:0] pp_lh, pp_hl;
  logic [31:0] quot, rem;
  logic [5:0]  step;
  logic        div_zero;
  logic        div_ovf;
  logic [32:0] rem_shift;
  logic [32:0] rem_try;
  logic        is_div;

  assign a_abs = a_in[31] ? 32'(0 - a_in) : a_in;
  assign b_abs = b_in[31] ? 32'(0 - b_in) : b_in;
  assign rem_shift = {rem, quot[31]};
  assign rem_try = rem_shift - {1'b0, ub};

  always_ff @(posedge clk) begin
    status.done <= !rst && ((state == S_MUL2) || ((state == S_DFIX) && is_div));
    if (rst) begin
      state <= S_IDLE;
      status.busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            status.busy <= 1'b1;
            is_signed <= (cmd.op == MD_MULT) || (cmd.op == MD_DIV);
            is_div <= (cmd.op == MD_DIV) || (cmd.op == MD_DIVU);
            a_neg <= a_in[31] && ((cmd.op == MD_MULT) || (cmd.op == MD_DIV));
            b_neg <= b_in[31] && ((cmd.op == MD_MULT) || (cmd.op == MD_DIV));
            if ((cmd.op == MD_MULT) || (cmd.op == MD_DIV)) begin
              ua <= a_abs;
              ub <= b_abs;
            end else begin
              ua <= a_in;
              ub <= b_in;
            end
            div_zero <= (b_in == 32'd0);
            div_ovf <= (cmd.op == MD_DIV) && (a_in == 32'h8000_0000) &&
                       (b_in == 32'hffff_ffff);
            state <= ((cmd.op == MD_DIV) || (cmd.op == MD_DIVU)) ? S_DIV : S_MUL0;
            step <= 6'd0;
            rem <= 32'd0;
            quot <= ((cmd.op == MD_MULT) || (cmd.op == MD_DIV)) ? a_abs : a_in;
          end
        end
        // 16x16 partial products, summed across S_MUL0, S_MUL1 and S_MUL2
        S_MUL0: begin
          acc <= {32'(ua[31:16] * ub[31:16]), 32'(ua[15:0] * ub[15:0])};
          pp_lh <= 32'(ua[15:0] * ub[31:16]);
          pp_hl <= 32'(ua[31:16] * ub[15:0]);
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc <= acc + {16'd0, pp_lh, 16'd0} + {16'd0, pp_hl, 16'd0};
          state <= S_MUL2;
        end
        S_MUL2: begin
          {hi_res, lo_res} <= (a_neg != b_neg) ? 64'(0 - acc) : acc;
          state <= S_IDLE;
          status.busy <= 1'b0;
        end
        // restoring divide, one quotient bit per cycle
        S_DIV: begin
          if (!rem_try[32]) begin
            rem <= rem_try[31:0];
            quot <= {quot[30:0], 1'b1};
          end else begin
            rem <= rem_shift[31:0];
            quot <= {quot[30:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd31) state <= S_DFIX;
        end
        S_DFIX: begin
          if (div_zero) begin
            lo_res <= (is_signed && a_neg) ? 32'd1 : 32'hffff_ffff;
            hi_res <= a_neg ? 32'(0 - ua) : ua;
          end else if (div_ovf) begin
            lo_res <= 32'h8000_0000;
            hi_res <= 32'd0;
          end else begin
            lo_res <= (a_neg != b_neg) ? 32'(0 - quot) : quot;
            hi_res <= a_neg ? 32'(0 - rem) : rem;
          end
          state <= S_IDLE;
          status.busy <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mxu_datapath.sv
module mxu_datapath
  import mxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic        cache_isolated,
  input  logic        boot_vectors,
  input  logic [31:0] instr_word,
  input  logic [31:0] rs_value,
  input  logic [31:0] rt_value,
  input  logic [31:0] pc_plus_four,
  input  logic        in_delay_slot,
  input  md_status_t  md_status,
  input  logic [31:0] md_hi,
  input  logic [31:0] md_lo,
  output logic        is_md,
  output md_op_t      md_op,
  output logic [4:0]  dest_index,
  output logic        dest_write,
  output logic [31:0] dest_value,
  output logic        redirect,
  output logic [31:0] redirect_target,
  output logic [2:0]  exception_code,
  output logic [31:0] exception_pc,
  output logic        exception_in_delay,
  output logic [3:0]  mem_op,
  output logic [31:0] mem_address,
  output logic [31:0] store_data
);

  logic [31:0] hi_word, lo_word;
  logic [5:0]  op, fn;
  logic [4:0]  rti, rdi, sh, sv;
  logic [31:0] imz, ims, btarget, link, jtarget, sum, diff, isum, ea;
  logic [4:0]  di;
  logic [31:0] dv, rtg;
  logic        wr, rd, set_hi, set_lo;
  exc_t        exc;
  mem_t        mop;
  logic [1:0]  amask;
  logic [31:0] sdata;
  logic        ld;

  assign op = instr_word[31:26];
  assign fn = instr_word[5:0];
  assign rti = instr_word[20:16];
  assign rdi = instr_word[15:11];
  assign sh = instr_word[10:6];
  assign sv = rs_value[4:0];
  assign imz = {16'd0, instr_word[15:0]};
  assign ims = {{16{instr_word[15]}}, instr_word[15:0]};
  assign btarget = pc_plus_four + {ims[29:0], 2'b00};
  assign link = pc_plus_four + 32'd4;
  assign jtarget = {pc_plus_four[31:28], instr_word[25:0], 2'b00};
  assign sum = rs_value + rt_value;
  assign diff = rs_value - rt_value;
  assign isum = rs_value + ims;
  assign ea = isum;

  assign is_md = (op == OP_SPECIAL) &&
                 ((fn == FN_MULT) || (fn == FN_MULTU) || (fn == FN_DIV) || (fn == FN_DIVU));
  always_comb begin
    case (fn)
      FN_MULT:  md_op = MD_MULT;
      FN_MULTU: md_op = MD_MULTU;
      FN_DIV:   md_op = MD_DIV;
      default:  md_op = MD_DIVU;
    endcase
  end

  always_comb begin
    di = 5'd0; dv = 32'd0; wr = 1'b0; rd = 1'b0; rtg = 32'd0;
    exc = EXC_NONE; mop = MEM_NONE; amask = 2'd0; sdata = 32'd0;
    set_hi = 1'b0; set_lo = 1'b0; ld = 1'b0;
    if (op == OP_SPECIAL) begin
      unique case (fn)
        FN_SLL:  begin di = rdi; dv = rt_value << sh; wr = 1'b1; end
        FN_SRL:  begin di = rdi; dv = rt_value >> sh; wr = 1'b1; end
        FN_SRA:  begin di = rdi; dv = $signed(rt_value) >>> sh; wr = 1'b1; end
        FN_SLLV: begin di = rdi; dv = rt_value << sv; wr = 1'b1; end
        FN_SRLV: begin di = rdi; dv = rt_value >> sv; wr = 1'b1; end
        FN_SRAV: begin di = rdi; dv = $signed(rt_value) >>> sv; wr = 1'b1; end
        FN_JR:   begin rd = 1'b1; rtg = rs_value; end
        FN_JALR: begin di = rdi; dv = link; wr = 1'b1; rd = 1'b1; rtg = rs_value; end
        FN_SYSCALL: exc = EXC_SYSCALL;
        FN_BREAK:   exc = EXC_BREAK;
        FN_MFHI: begin di = rdi; dv = hi_word; wr = 1'b1; end
        FN_MTHI: set_hi = 1'b1;
        FN_MFLO: begin di = rdi; dv = lo_word; wr = 1'b1; end
        FN_MTLO: set_lo = 1'b1;
        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: ;
        FN_ADD: begin
          if ((rs_value[31] ^ sum[31]) & (rt_value[31] ^ sum[31])) exc = EXC_OVERFLOW;
          else begin di = rdi; dv = sum; wr = 1'b1; end
        end
        FN_ADDU: begin di = rdi; dv = sum; wr = 1'b1; end
        FN_SUB: begin
          if ((rs_value[31] ^ rt_value[31]) & (rs_value[31] ^ diff[31])) exc = EXC_OVERFLOW;
          else begin di = rdi; dv = diff; wr = 1'b1; end
        end
        FN_SUBU: begin di = rdi; dv = diff; wr = 1'b1; end
        FN_AND:  begin di = rdi; dv = rs_value & rt_value; wr = 1'b1; end
        FN_OR:   begin di = rdi; dv = rs_value | rt_value; wr = 1'b1; end
        FN_XOR:  begin di = rdi; dv = rs_value ^ rt_value; wr = 1'b1; end
        FN_NOR:  begin di = rdi; dv = ~(rs_value | rt_value); wr = 1'b1; end
        FN_SLT:  begin
          di = rdi; dv = {31'd0, $signed(rs_value) < $signed(rt_value)}; wr = 1'b1;
        end
        FN_SLTU: begin di = rdi; dv = {31'd0, rs_value < rt_value}; wr = 1'b1; end
        default: exc = EXC_RESERVED;
      endcase
    end else if (op == OP_REGIMM) begin
      if ((rti == RI_BLTZ) || (rti == RI_BLTZAL)) begin
        if (rs_value[31]) begin rd = 1'b1; rtg = btarget; end
      end else if ((rti == RI_BGEZ) || (rti == RI_BGEZAL)) begin
        if (!rs_value[31]) begin rd = 1'b1; rtg = btarget; end
      end else begin
        exc = EXC_RESERVED;
      end
      if ((exc == EXC_NONE) && rti[4]) begin di = LinkReg; dv = link; wr = 1'b1; end
    end else begin
      unique case (op)
        OP_J:   begin rd = 1'b1; rtg = jtarget; end
        OP_JAL: begin rd = 1'b1; rtg = jtarget; di = LinkReg; dv = link; wr = 1'b1; end
        OP_BEQ: if (rs_value == rt_value) begin rd = 1'b1; rtg = btarget; end
        OP_BNE: if (rs_value != rt_value) begin rd = 1'b1; rtg = btarget; end
        OP_BLEZ: if (rs_value[31] || (rs_value == 32'd0)) begin rd = 1'b1; rtg = btarget; end
        OP_BGTZ: if (!rs_value[31] && (rs_value != 32'd0)) begin
          rd = 1'b1; rtg = btarget;
        end
        OP_ADDI: begin
          if ((rs_value[31] ^ isum[31]) & (ims[31] ^ isum[31])) exc = EXC_OVERFLOW;
          else begin di = rti; dv = isum; wr = 1'b1; end
        end
        OP_ADDI_NOTRAP: begin di = rti; dv = isum; wr = 1'b1; end
        OP_SLTI: begin
          di = rti; dv = {31'd0, $signed(rs_value) < $signed(ims)}; wr = 1'b1;
        end
        OP_SLTI_UNS: begin di = rti; dv = {31'd0, rs_value < ims}; wr = 1'b1; end
        OP_ANDI: begin di = rti; dv = rs_value & imz; wr = 1'b1; end
        OP_ORI:  begin di = rti; dv = rs_value | imz; wr = 1'b1; end
        OP_XORI: begin di = rti; dv = rs_value ^ imz; wr = 1'b1; end
        OP_LUI:  begin di = rti; dv = {instr_word[15:0], 16'd0}; wr = 1'b1; end
        OP_LB:  begin mop = MEM_LB;  amask = 2'd0; ld = 1'b1; end
        OP_LBU: begin mop = MEM_LBU; amask = 2'd0; ld = 1'b1; end
        OP_LH:  begin mop = MEM_LH;  amask = 2'd1; ld = 1'b1; end
        OP_LHU: begin mop = MEM_LHU; amask = 2'd1; ld = 1'b1; end
        OP_LW:  begin mop = MEM_LW;  amask = 2'd3; ld = 1'b1; end
        OP_SB:  begin mop = MEM_SB;  amask = 2'd0; sdata = {24'd0, rt_value[7:0]}; end
        OP_SH:  begin mop = MEM_SH;  amask = 2'd1; sdata = {16'd0, rt_value[15:0]}; end
        OP_SW:  begin mop = MEM_SW;  amask = 2'd3; sdata = rt_value; end
        OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LWL, OP_LWR, OP_SWL, OP_SWR,
        OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC2, OP_SWC3:
          exc = EXC_OUTSIDE;
        default: exc = EXC_RESERVED;
      endcase
      if (mop != MEM_NONE) begin
        if ((ea[1:0] & amask) != 2'd0) begin
          exc = EXC_OUTSIDE; mop = MEM_NONE; sdata = 32'd0; ld = 1'b0;
        end else if (cache_isolated) begin
          mop = MEM_NONE; sdata = 32'd0; ld = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hi_word <= 32'd0;
      lo_word <= 32'd0;
    end else if (md_status.done) begin
      hi_word <= md_hi;
      lo_word <= md_lo;
    end else if (load) begin
      if (set_hi) hi_word <= rs_value;
      if (set_lo) lo_word <= rs_value;
    end
  end

  // result registers, held while the output is stalled
  always_ff @(posedge clk) begin
    if (load) begin
      exception_code <= exc;
      if (exc != EXC_NONE) begin
        dest_index <= 5'd0; dest_write <= 1'b0; dest_value <= 32'd0;
        exception_pc <= in_delay_slot ? pc_plus_four - 32'd8 : pc_plus_four - 32'd4;
        exception_in_delay <= in_delay_slot;
        redirect <= (exc != EXC_OUTSIDE);
        redirect_target <= (exc == EXC_OUTSIDE) ? 32'd0 :
                           (boot_vectors ? BevVector : NormalVector);
        mem_op <= MEM_NONE; mem_address <= 32'd0; store_data <= 32'd0;
      end else begin
        // an issued load names rt but the data is written elsewhere
        dest_index <= wr ? di : (ld ? rti : 5'd0);
        dest_write <= wr && (di != 5'd0);
        dest_value <= (wr && (di != 5'd0)) ? dv : 32'd0;
        exception_pc <= 32'd0; exception_in_delay <= 1'b0;
        redirect <= rd;
        redirect_target <= rd ? rtg : 32'd0;
        mem_op <= mop;
        mem_address <= (mop != MEM_NONE) ? ea : 32'd0;
        store_data <= sdata;
      end
    end
  end

endmodule

// File: hdl/mxu_ctrl.sv
module mxu_ctrl
  import mxu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       is_md,
  input  md_op_t     md_op,
  input  md_status_t md_status,
  output logic       load,
  output md_cmd_t    md_cmd
);

  typedef enum logic [1:0] {C_IDLE, C_WAIT} ctrl_state_t;

  ctrl_state_t state;
  logic        accept;

  // a new item is taken when no multiply/divide is pending and the result register is empty or leaving
  assign in_stall = (state != C_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign load = accept;
  assign md_cmd.start = accept && is_md;
  assign md_cmd.op = md_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (accept) begin
            out_valid <= !is_md;
            if (is_md) state <= C_WAIT;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        C_WAIT: begin
          if (md_status.done) begin
            out_valid <= 1'b1;
            state <= C_IDLE;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mips1_integer_execute_unit.sv
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// input    | in_valid, in_stall, instr_word .. slot    | in
// output   | out_valid, out_stall, dest_index .. store | out
// config   | cfg_write, cfg_index, cfg_data            | in
// instructions are taken back to back while the output is not stalled; mult,
// multu, div and divu run on the shared multiply/divide unit (16-bit partial
// products, one quotient bit per cycle); the input stalls meanwhile.
// synchronous reset clears HI, LO and control; cache_isolated to 0,
// boot_vectors to 1. a stalled result holds and blocks the next transfer.
module mips1_integer_execute_unit
  import mxu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  input  logic [31:0] rs_value,
  input  logic [31:0] rt_value,
  input  logic [31:0] pc_plus_four,
  input  logic        in_delay_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  dest_index,
  output logic        dest_write,
  output logic [31:0] dest_value,
  output logic        redirect,
  output logic [31:0] redirect_target,
  output logic [2:0]  exception_code,
  output logic [31:0] exception_pc,
  output logic        exception_in_delay,
  output logic [3:0]  mem_op,
  output logic [31:0] mem_address,
  output logic [31:0] store_data
);

  logic        cache_isolated, boot_vectors;
  logic        load, is_md;
  md_op_t      md_op;
  md_cmd_t     md_cmd;
  md_status_t  md_status;
  logic [31:0] md_hi, md_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_isolated <= 1'b0;
      boot_vectors <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == 1'b0) cache_isolated <= cfg_data;
      else boot_vectors <= cfg_data;
    end
  end

  mxu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .is_md, .md_op, .md_status, .load, .md_cmd
  );

  mxu_muldiv u_md (
    .clk, .rst, .cmd(md_cmd), .a_in(rs_value), .b_in(rt_value),
    .status(md_status), .hi_res(md_hi), .lo_res(md_lo)
  );

  mxu_datapath u_dp (
    .clk, .rst, .load, .cache_isolated, .boot_vectors,
    .instr_word, .rs_value, .rt_value, .pc_plus_four, .in_delay_slot,
    .md_status, .md_hi, .md_lo, .is_md, .md_op,
    .dest_index, .dest_write, .dest_value, .redirect, .redirect_target,
    .exception_code, .exception_pc, .exception_in_delay,
    .mem_op, .mem_address, .store_data
  );

`ifndef SYNTH
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(dest_write && (dest_index == 5'd0)))
    else $error("write to register zero");
  a_exc_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (exception_code != EXC_NONE)) |-> (!dest_write && (mem_op == MEM_NONE)))
    else $error("exception with side effect");
  a_md_stall: assert property (@(posedge clk) disable iff (rst)
    md_status.busy |-> in_stall)
    else $error("input taken during multiply/divide");
`endif

endmodule

// File: dv/mips1_integer_execute_unit_test.sv
module mips1_integer_execute_unit_test
  import mxu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] iw;
    logic [31:0] rs;
    logic [31:0] rt;
    logic [31:0] pc4;
    logic        dly;
  } instr_item_t;

  typedef struct {
    logic [4:0]  di;
    logic        dw;
    logic [31:0] dv;
    logic        rd;
    logic [31:0] tgt;
    exc_t        exc;
    logic [31:0] epc;
    logic        edly;
    mem_t        mop;
    logic [31:0] maddr;
    logic [31:0] sdata;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] instr_word = '0, rs_value = '0, rt_value = '0, pc_plus_four = '0;
  logic in_delay_slot = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] dest_index;
  logic dest_write, redirect, exception_in_delay;
  logic [31:0] dest_value, redirect_target, exception_pc, mem_address, store_data;
  logic [2:0] exception_code;
  logic [3:0] mem_op;

  mips1_integer_execute_unit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  instr_item_t  pending_instrs[$];
  exec_result_t expected_results[$];
  logic [31:0] hi_reg, lo_reg;
  logic isolated_cfg, bev_cfg;
  int errors = 0;
  int n_results = 0;
  int n_exc = 0;
  int n_mem = 0;
  int idle_cycles = 0;
  logic calm = 1'b0;
  logic timed_out = 1'b0;
  logic in_taken = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  function automatic void set_divide(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ua, ub, q, r;
    if (b == 0) begin
      lo_reg = a[31] ? 32'd1 : 32'hffffffff;
      hi_reg = a;
    end else if (a == 32'h80000000 && b == 32'hffffffff) begin
      lo_reg = 32'h80000000;
      hi_reg = 0;
    end else begin
      ua = a[31] ? -a : a;
      ub = b[31] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      lo_reg = (a[31] != b[31]) ? -q : q;
      hi_reg = a[31] ? -r : r;
    end
  endfunction

  function automatic exec_result_t execute_instr(input instr_item_t it);
    exec_result_t e;
    logic [5:0] op, fn;
    logic [4:0] rti, rdi, sh;
    logic [31:0] imz, ims, bt, link, r, ea;
    logic [63:0] p;
    logic wr;
    logic [1:0] amask;
    mem_t code;
    op = it.iw[31:26];
    fn = it.iw[5:0];
    rti = it.iw[20:16];
    rdi = it.iw[15:11];
    sh = it.iw[10:6];
    imz = {16'h0, it.iw[15:0]};
    ims = {{16{it.iw[15]}}, it.iw[15:0]};
    bt = it.pc4 + (ims << 2);
    link = it.pc4 + 4;
    e = '{di: 0, dw: 0, dv: 0, rd: 0, tgt: 0, exc: EXC_NONE, epc: 0, edly: 0,
          mop: MEM_NONE, maddr: 0, sdata: 0};
    wr = 0;
    if (op == OP_SPECIAL) begin
      wr = 1;
      e.di = rdi;
      case (fn)
        FN_SLL:  e.dv = it.rt << sh;
        FN_SRL:  e.dv = it.rt >> sh;
        FN_SRA:  e.dv = $signed(it.rt) >>> sh;
        FN_SLLV: e.dv = it.rt << it.rs[4:0];
        FN_SRLV: e.dv = it.rt >> it.rs[4:0];
        FN_SRAV: e.dv = $signed(it.rt) >>> it.rs[4:0];
        FN_JR: begin wr = 0; e.rd = 1; e.tgt = it.rs; end
        FN_JALR: begin e.dv = link; e.rd = 1; e.tgt = it.rs; end
        FN_SYSCALL: begin wr = 0; e.exc = EXC_SYSCALL; end
        FN_BREAK: begin wr = 0; e.exc = EXC_BREAK; end
        FN_MFHI: e.dv = hi_reg;
        FN_MTHI: begin wr = 0; hi_reg = it.rs; end
        FN_MFLO: e.dv = lo_reg;
        FN_MTLO: begin wr = 0; lo_reg = it.rs; end
        FN_MULT: begin
          wr = 0;
          p = $signed({{32{it.rs[31]}}, it.rs}) * $signed({{32{it.rt[31]}}, it.rt});
          {hi_reg, lo_reg} = p;
        end
        FN_MULTU: begin
          wr = 0;
          p = {32'h0, it.rs} * {32'h0, it.rt};
          {hi_reg, lo_reg} = p;
        end
        FN_DIV: begin wr = 0; set_divide(it.rs, it.rt); end
        FN_DIVU: begin
          wr = 0;
          if (it.rt == 0) begin lo_reg = 32'hffffffff; hi_reg = it.rs; end
          else begin lo_reg = it.rs / it.rt; hi_reg = it.rs % it.rt; end
        end
        FN_ADD: begin
          r = it.rs + it.rt;
          if (((it.rs ^ r) & (it.rt ^ r)) >> 31) begin wr = 0; e.exc = EXC_OVERFLOW; end
          else e.dv = r;
        end
        FN_ADDU: e.dv = it.rs + it.rt;
        FN_SUB: begin
          r = it.rs - it.rt;
          if (((it.rs ^ it.rt) & (it.rs ^ r)) >> 31) begin wr = 0; e.exc = EXC_OVERFLOW; end
          else e.dv = r;
        end
        FN_SUBU: e.dv = it.rs - it.rt;
        FN_AND: e.dv = it.rs & it.rt;
        FN_OR:  e.dv = it.rs | it.rt;
        FN_XOR: e.dv = it.rs ^ it.rt;
        FN_NOR: e.dv = ~(it.rs | it.rt);
        FN_SLT:  e.dv = {31'h0, $signed(it.rs) < $signed(it.rt)};
        FN_SLTU: e.dv = {31'h0, it.rs < it.rt};
        default: begin wr = 0; e.exc = EXC_RESERVED; end
      endcase
    end else if (op == OP_REGIMM) begin
      if (rti == RI_BLTZ || rti == RI_BLTZAL) begin
        if (it.rs[31]) begin e.rd = 1; e.tgt = bt; end
      end else if (rti == RI_BGEZ || rti == RI_BGEZAL) begin
        if (!it.rs[31]) begin e.rd = 1; e.tgt = bt; end
      end else e.exc = EXC_RESERVED;
      if (e.exc == EXC_NONE && rti[4]) begin wr = 1; e.di = LinkReg; e.dv = link; end
    end else begin
      e.di = rti;
      case (op)
        OP_J: begin e.rd = 1; e.tgt = {it.pc4[31:28], it.iw[25:0], 2'b00}; end
        OP_JAL: begin
          e.rd = 1; e.tgt = {it.pc4[31:28], it.iw[25:0], 2'b00};
          wr = 1; e.di = LinkReg; e.dv = link;
        end
        OP_BEQ:  if (it.rs == it.rt) begin e.rd = 1; e.tgt = bt; end
        OP_BNE:  if (it.rs != it.rt) begin e.rd = 1; e.tgt = bt; end
        OP_BLEZ: if (it.rs[31] || it.rs == 0) begin e.rd = 1; e.tgt = bt; end
        OP_BGTZ: if (!it.rs[31] && it.rs != 0) begin e.rd = 1; e.tgt = bt; end
        OP_ADDI: begin
          r = it.rs + ims;
          if (((it.rs ^ r) & (ims ^ r)) >> 31) e.exc = EXC_OVERFLOW;
          else begin wr = 1; e.dv = r; end
        end
        OP_ADDI_NOTRAP: begin wr = 1; e.dv = it.rs + ims; end
        OP_SLTI:  begin wr = 1; e.dv = {31'h0, $signed(it.rs) < $signed(ims)}; end
        OP_SLTI_UNS: begin wr = 1; e.dv = {31'h0, it.rs < ims}; end
        OP_ANDI:  begin wr = 1; e.dv = it.rs & imz; end
        OP_ORI:   begin wr = 1; e.dv = it.rs | imz; end
        OP_XORI:  begin wr = 1; e.dv = it.rs ^ imz; end
        OP_LUI:   begin wr = 1; e.dv = imz << 16; end
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
          ea = it.rs + ims;
          case (op)
            OP_LB:  begin code = MEM_LB;  amask = 0; end
            OP_LBU: begin code = MEM_LBU; amask = 0; end
            OP_LH:  begin code = MEM_LH;  amask = 1; end
            OP_LHU: begin code = MEM_LHU; amask = 1; end
            OP_LW:  begin code = MEM_LW;  amask = 3; end
            OP_SB:  begin code = MEM_SB;  amask = 0; end
            OP_SH:  begin code = MEM_SH;  amask = 1; end
            default: begin code = MEM_SW; amask = 3; end
          endcase
          e.di = 0;
          if ((ea[1:0] & amask) != 0) e.exc = EXC_OUTSIDE;
          else if (!isolated_cfg) begin
            e.mop = code;
            e.maddr = ea;
            if (code <= MEM_LW) e.di = rti;
            else if (code == MEM_SB) e.sdata = it.rt & 32'hff;
            else if (code == MEM_SH) e.sdata = it.rt & 32'hffff;
            else e.sdata = it.rt;
          end
        end
        OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LWL, OP_LWR, OP_SWL, OP_SWR,
        OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3, OP_SWC0, OP_SWC1, OP_SWC2, OP_SWC3:
          e.exc = EXC_OUTSIDE;
        default: e.exc = EXC_RESERVED;
      endcase
    end
    if (wr) begin
      if (e.di != 0) e.dw = 1;
      else e.dv = 0;
    end else begin
      e.dv = 0;
      if (e.mop == MEM_NONE || e.mop > MEM_LW) e.di = 0;
    end
    if (e.exc != EXC_NONE) begin
      exec_result_t x;
      x = '{di: 0, dw: 0, dv: 0, rd: 0, tgt: 0, exc: e.exc, epc: 0, edly: it.dly,
            mop: MEM_NONE, maddr: 0, sdata: 0};
      x.epc = it.dly ? it.pc4 - 8 : it.pc4 - 4;
      if (e.exc != EXC_OUTSIDE) begin
        x.rd = 1;
        x.tgt = bev_cfg ? BevVector : NormalVector;
      end
      return x;
    end
    return e;
  endfunction

  // driver: next item goes out at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_instrs.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          instr_item_t it;
          it = pending_instrs.pop_front();
          expected_results = {expected_results, execute_instr(it)};
          instr_word <= it.iw;
          rs_value <= it.rs;
          rt_value <= it.rt;
          pc_plus_four <= it.pc4;
          in_delay_slot <= it.dly;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      in_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          exec_result_t w;
          w = expected_results.pop_front();
          if (dest_index != w.di) report_mismatch("dest_index", dest_index, w.di);
          if (dest_write != w.dw) report_mismatch("dest_write", dest_write, w.dw);
          if (dest_value != w.dv) report_mismatch("dest_value", dest_value, w.dv);
          if (redirect != w.rd) report_mismatch("redirect", redirect, w.rd);
          if (redirect_target != w.tgt)
            report_mismatch("redirect_target", redirect_target, w.tgt);
          if (exception_code != w.exc) report_mismatch("exception_code", exception_code, w.exc);
          if (exception_pc != w.epc) report_mismatch("exception_pc", exception_pc, w.epc);
          if (exception_in_delay != w.edly)
            report_mismatch("exception_in_delay", exception_in_delay, w.edly);
          if (mem_op != w.mop) report_mismatch("mem_op", mem_op, w.mop);
          if (mem_address != w.maddr) report_mismatch("mem_address", mem_address, w.maddr);
          if (store_data != w.sdata) report_mismatch("store_data", store_data, w.sdata);
          if (w.exc != EXC_NONE) n_exc++;
          if (w.mop != MEM_NONE) n_mem++;
          n_results++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      timed_out = 1'b1;
      $display("mips1_integer_execute_unit_test: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h80000000;
      3: return 32'h7fffffff;
      4: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    logic [5:0] ops[$] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
      OP_ADDI, OP_ADDI_NOTRAP, OP_SLTI, OP_SLTI_UNS, OP_ANDI, OP_ORI, OP_XORI, OP_LUI,
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW, OP_COP0, OP_LWL, OP_SWC2};
    logic [5:0] fns[$] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
      FN_JALR, FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
      FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
      FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0: ;
      1, 2, 3, 4: begin w[31:26] = OP_SPECIAL; w[5:0] = fns[$urandom_range(fns.size() - 1)]; end
      5: begin
        w[31:26] = OP_REGIMM;
        w[20:16] = {1'($urandom_range(1)), 3'b000, 1'($urandom_range(1))};
      end
      default: w[31:26] = ops[$urandom_range(ops.size() - 1)];
    endcase
    return w;
  endfunction

  task automatic add_instr(input logic [31:0] iw, input logic [31:0] rs,
                           input logic [31:0] rt);
    instr_item_t it;
    it.iw = iw;
    it.rs = rs;
    it.rt = rt;
    it.pc4 = $urandom;
    it.dly = 1'($urandom_range(1));
    pending_instrs = {pending_instrs, it};
  endtask

  task automatic write_config(input logic idx, input logic val);
    while (pending_instrs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx) bev_cfg = val;
    else isolated_cfg = val;
  endtask

  initial begin
    hi_reg = 0;
    lo_reg = 0;
    isolated_cfg = 0;
    bev_cfg = 1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: overflow, division corners, hi/lo moves, links, r0 target
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD}, 32'h7fffffff, 32'd1);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd0, FN_SUB}, 32'h80000000, 32'd1);
    add_instr({OP_ADDI, 5'd1, 5'd2, 16'h0001}, 32'h7fffffff, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIV}, 32'h80000000, 32'hffffffff);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO}, 0, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIV}, 32'hfffffff9, 32'd0);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFHI}, 0, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIV}, 32'hfffffff9, 32'd2);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFHI}, 0, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_DIVU}, 32'h12345678, 32'd0);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO}, 0, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd2, 5'd0, 5'd0, FN_MULT}, 32'hffffffff, 32'h80000000);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd4, 5'd0, FN_MFHI}, 0, 0);
    add_instr({OP_SPECIAL, 5'd1, 5'd0, 5'd0, 5'd0, FN_MTLO}, 32'hdeadbeef, 0);
    add_instr({OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, FN_MFLO}, 0, 0);
    add_instr({OP_REGIMM, 5'd1, RI_BLTZAL, 16'h8000}, 32'h1, 0);
    add_instr({OP_REGIMM, 5'd1, RI_BGEZAL, 16'h7fff}, 32'h1, 0);
    add_instr({OP_REGIMM, 5'd1, 5'd5, 16'h0}, 32'h1, 0);
    add_instr({OP_SPECIAL, 20'h0, FN_SYSCALL}, 0, 0);
    add_instr({OP_SPECIAL, 20'hfffff, FN_BREAK}, 0, 0);
    add_instr({OP_SPECIAL, 20'h0, 6'h3f}, 0, 0);
    add_instr({6'h3f, 26'h0}, 0, 0);
    add_instr({OP_LW, 5'd1, 5'd2, 16'h0002}, 32'h0, 32'hffffffff);
    add_instr({OP_SB, 5'd1, 5'd2, 16'hffff}, 32'h1, 32'hffffffff);
    add_instr({OP_JAL, 26'h3ffffff}, 0, 0);
    write_config(1'b0, 1'b1);
    write_config(1'b1, 1'b0);
    for (int phase = 0; phase < 4; phase++) begin
      calm = (phase == 2);
      for (int n = 0; n < 385; n++) add_instr(rand_word(), rand_value(), rand_value());
      if (phase < 3) begin
        write_config(1'b0, phase[0]);
        write_config(1'b1, phase[1]);
      end
    end
    while (pending_instrs.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!timed_out) begin
      $display("checked %0d instruction results: %0d exceptions, %0d memory requests",
               n_results, n_exc, n_mem);
      $display("configs covered both cache isolation and both vector settings");
      if (errors == 0) begin
        $display("mips1_integer_execute_unit_test: done, clean");
      end else begin
        $display("mips1_integer_execute_unit_test: done, errors");
      end
      $finish;
    end
  end

endmodule
